FILE: hw/rtl/ini_tok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ini_tok_pkg
// Types and character constants shared by the INI text tokenizer modules.
// ----------------------------------------------------------------------------
package ini_tok_pkg;

    // Lexer modes. The three spare codes of the 3-bit field are treated as idle.
    typedef enum logic [2:0] {
        LEX_IDLE    = 3'd0,
        LEX_COMMENT = 3'd1,
        LEX_SECTION = 3'd2,
        LEX_KEY     = 3'd3,
        LEX_VALUE   = 3'd4
    } t_lex_mode;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    // Space and everything below it count as blank.
    localparam logic [7:0] BLANK_MAX  = 8'd32;

    localparam int SPAN_BITS = 16;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]           token_kind;
        logic [SPAN_BITS-1:0] span_first;
        logic [SPAN_BITS-1:0] span_past;
        logic                 pos_overflow;
    } t_out_beat;

endpackage
`default_nettype wire

FILE: hw/rtl/ini_tok_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ini_tok_lexer
// Lexer state and position counter; steps once per byte and reports the
// token that the byte completes, if any.
// ----------------------------------------------------------------------------
module ini_tok_lexer #(
    parameter int POS_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  ini_tok_pkg::t_in_beat   i_beat,
    output logic                    o_tok_valid,
    output ini_tok_pkg::t_out_beat  o_tok
);
    import ini_tok_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    t_lex_mode           r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_first, n_first;
    logic [POS_BITS-1:0] r_past, n_past;
    logic                r_begun, n_begun;
    logic                r_sat, n_sat;

    logic [7:0]          w_c;
    logic                w_blank;
    logic [POS_BITS-1:0] w_next;
    logic                w_at_max;
    logic [1:0]          w_kind;
    logic [POS_BITS-1:0] w_span_first;
    logic [POS_BITS-1:0] w_span_past;

    assign w_c      = i_beat.text_byte;
    assign w_blank  = (w_c <= BLANK_MAX);
    assign w_at_max = (r_pos == POS_MAX);
    assign w_next   = w_at_max ? POS_MAX : r_pos + 1'b1;

    always_comb begin
        n_mode       = r_mode;
        n_first      = r_first;
        n_past       = r_past;
        n_begun      = r_begun;
        n_sat        = r_sat | w_at_max;
        n_pos        = w_next;
        o_tok_valid  = 1'b0;
        w_kind       = KIND_SECTION;
        w_span_first = r_first;
        w_span_past  = r_past;
        case (r_mode)
            LEX_COMMENT: begin
                if (w_c == CH_NEWLINE) begin
                    n_mode = LEX_IDLE;
                end
            end
            LEX_SECTION: begin
                if (w_c == CH_RBRACK) begin
                    o_tok_valid = 1'b1;
                    w_kind      = KIND_SECTION;
                    w_span_past = r_pos;
                    n_mode      = LEX_IDLE;
                end
            end
            LEX_KEY: begin
                if (w_c == CH_EQUALS) begin
                    o_tok_valid = 1'b1;
                    w_kind      = KIND_KEY;
                    n_mode      = LEX_VALUE;
                    n_begun     = 1'b0;
                end else if (!w_blank) begin
                    n_past = w_next;
                end
            end
            LEX_VALUE: begin
                if (w_c == CH_NEWLINE) begin
                    o_tok_valid = 1'b1;
                    w_kind      = KIND_VALUE;
                    // A value with nothing but blanks is empty at the newline.
                    if (!r_begun) begin
                        w_span_first = r_pos;
                        w_span_past  = r_pos;
                    end
                    n_mode  = LEX_IDLE;
                    n_begun = 1'b0;
                end else if (!w_blank) begin
                    if (!r_begun) begin
                        n_first = r_pos;
                        n_begun = 1'b1;
                    end
                    n_past = w_next;
                end
            end
            default: begin
                n_mode = LEX_IDLE;
                if (w_c == CH_HASH) begin
                    n_mode = LEX_COMMENT;
                end else if (w_c == CH_LBRACK) begin
                    n_mode  = LEX_SECTION;
                    n_first = w_next;
                end else if (w_c == CH_EQUALS) begin
                    // A key that opens with '=' is an empty span at the '='.
                    o_tok_valid  = 1'b1;
                    w_kind       = KIND_KEY;
                    w_span_first = r_pos;
                    w_span_past  = r_pos;
                    n_mode       = LEX_VALUE;
                    n_begun      = 1'b0;
                end else if (!w_blank) begin
                    n_mode  = LEX_KEY;
                    n_first = r_pos;
                    n_past  = w_next;
                end
            end
        endcase
    end

    always_comb begin
        o_tok.token_kind   = w_kind;
        o_tok.span_first   = SPAN_BITS'(w_span_first);
        o_tok.span_past    = SPAN_BITS'(w_span_past);
        o_tok.pos_overflow = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LEX_IDLE;
            r_pos   <= '0;
            r_first <= '0;
            r_past  <= '0;
            r_begun <= 1'b0;
            r_sat   <= 1'b0;
        end else if (i_step) begin
            if (i_beat.last_byte) begin
                // End of text: anything left open is dropped.
                r_mode  <= LEX_IDLE;
                r_pos   <= '0;
                r_first <= '0;
                r_past  <= '0;
                r_begun <= 1'b0;
                r_sat   <= 1'b0;
            end else begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_first <= n_first;
                r_past  <= n_past;
                r_begun <= n_begun;
                r_sat   <= n_sat;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ini_text_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ini_text_tokenizer
// Byte-serial INI lexer that emits section, key and value spans as offsets.
// ----------------------------------------------------------------------------
// The block takes one text byte per beat and counts byte offsets itself from
// zero; each beat may yield one token with the start and just-past-end offsets
// of a section name, a trimmed key or a trimmed value. It sustains one byte per
// cycle: a byte is held in the input register while the lexer steps its small
// state update, and its token is then registered in the result register. Both
// registers keep moving while the other side stalls, as long as the result
// register is free or being taken. After a beat with last_byte set, the lexer
// and its offset counter start over.
// ----------------------------------------------------------------------------
module ini_text_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  ini_tok_pkg::t_in_beat   i_in_beat,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output ini_tok_pkg::t_out_beat  o_out_beat
);
    import ini_tok_pkg::*;

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic      w_advance;
    logic      w_tok_valid;
    t_out_beat w_tok;

    // The held byte moves on once the result register can take its token.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    ini_tok_lexer #(
        .POS_BITS (POS_BITS)
    ) u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_beat      (r_in_beat),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_tok_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_tok_valid) begin
            r_out_beat <= w_tok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
`default_nettype wire

FILE: tb/tb_ini_text_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_ini_text_tokenizer
// Self-checking testbench for the byte-serial INI span tokenizer.
// ----------------------------------------------------------------------------
// Bytes of generated INI text go in through the valid/ready input channel. A
// scoreboard class keeps its own lexer state, predicts any span token of every
// accepted byte and compares each output beat with the oldest prediction.
// A short directed text comes first. Random texts follow, mostly well formed
// with sections, comments, keys and values, plus noise and truncated endings.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ini_text_tokenizer;
    import ini_tok_pkg::*;

    localparam int POS_BITS    = 16;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int RANDOM_BYTES = 1700;

    class span_scoreboard;
        t_lex_mode             mode;
        logic [POS_BITS-1:0]   pos;
        logic [POS_BITS-1:0]   span_lo;
        logic [POS_BITS-1:0]   span_hi;
        bit                    value_seen;
        bit                    pos_sat;
        t_out_beat             pending_spans[$];
        int unsigned           failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            mode       = LEX_IDLE;
            pos        = '0;
            span_lo    = '0;
            span_hi    = '0;
            value_seen = 1'b0;
            pos_sat    = 1'b0;
        endfunction

        function void push_span(logic [1:0] kind, logic [POS_BITS-1:0] lo,
                                logic [POS_BITS-1:0] hi);
            t_out_beat t;
            t.token_kind   = kind;
            t.span_first   = SPAN_BITS'(lo);
            t.span_past    = SPAN_BITS'(hi);
            t.pos_overflow = pos_sat;
            pending_spans.push_back(t);
        endfunction

        function void note_input(t_in_beat b);
            logic [7:0]          c;
            logic [POS_BITS-1:0] here;
            logic [POS_BITS-1:0] nxt;
            bit                  blank;
            c     = b.text_byte;
            blank = (c <= BLANK_MAX);
            here  = pos;
            // The counter sticks at its top value once it gets there.
            if (here == '1) begin
                nxt     = '1;
                pos_sat = 1'b1;
            end else begin
                nxt = here + 1'b1;
            end
            case (mode)
                LEX_COMMENT: begin
                    if (c == CH_NEWLINE) mode = LEX_IDLE;
                end
                LEX_SECTION: begin
                    if (c == CH_RBRACK) begin
                        push_span(KIND_SECTION, span_lo, here);
                        mode = LEX_IDLE;
                    end
                end
                LEX_KEY: begin
                    if (c == CH_EQUALS) begin
                        push_span(KIND_KEY, span_lo, span_hi);
                        mode       = LEX_VALUE;
                        value_seen = 1'b0;
                    end else if (!blank) begin
                        span_hi = nxt;
                    end
                end
                LEX_VALUE: begin
                    if (c == CH_NEWLINE) begin
                        if (value_seen) push_span(KIND_VALUE, span_lo, span_hi);
                        else push_span(KIND_VALUE, here, here);
                        mode       = LEX_IDLE;
                        value_seen = 1'b0;
                    end else if (!blank) begin
                        if (!value_seen) begin
                            span_lo    = here;
                            value_seen = 1'b1;
                        end
                        span_hi = nxt;
                    end
                end
                default: begin
                    mode = LEX_IDLE;
                    if (c == CH_HASH) begin
                        mode = LEX_COMMENT;
                    end else if (c == CH_LBRACK) begin
                        mode    = LEX_SECTION;
                        span_lo = nxt;
                    end else if (c == CH_EQUALS) begin
                        push_span(KIND_KEY, here, here);
                        mode       = LEX_VALUE;
                        value_seen = 1'b0;
                    end else if (!blank) begin
                        mode    = LEX_KEY;
                        span_lo = here;
                        span_hi = nxt;
                    end
                end
            endcase
            pos = nxt;
            if (b.last_byte) restart();
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_spans.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected token: kind %0d first %0d past %0d ovf %0b",
                             got.token_kind, got.span_first, got.span_past,
                             got.pos_overflow);
                return;
            end
            want = pending_spans.pop_front();
            if (got.token_kind !== want.token_kind || got.span_first !== want.span_first ||
                got.span_past !== want.span_past ||
                got.pos_overflow !== want.pos_overflow) begin
                failures++;
                if (failures <= 10)
                    $display("token mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             want.token_kind, want.span_first, want.span_past,
                             want.pos_overflow, got.token_kind, got.span_first,
                             got.span_past, got.pos_overflow);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_beat    in_beat = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_beat;

    span_scoreboard spans;
    logic [7:0]     text_q[$];
    int unsigned    bytes_sent = 0;
    int unsigned    cycles = 0;
    bit             sender_pace = 1'b0;
    bit             receiver_pace = 1'b0;

    ini_text_tokenizer #(.POS_BITS(POS_BITS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Scoreboard taps: signals read at the edge still hold their pre-edge values.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) spans.note_input(in_beat);
        if (rst_n && out_valid && out_ready) spans.check_result(out_beat);
    end

    function automatic int draw_gap(bit paced);
        if (!paced) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    // Output side: stall a random number of cycles before taking each beat.
    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = draw_gap(receiver_pace);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic logic [7:0] byte_except(int lo, logic [7:0] bad_a,
                                               logic [7:0] bad_b, logic [7:0] bad_c);
        logic [7:0] b;
        do b = 8'($urandom_range(lo, 255));
        while (b == bad_a || b == bad_b || b == bad_c);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte(bit allow_newline);
        logic [7:0] b;
        b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 32)) : BLANK_MAX;
        if (!allow_newline && b == CH_NEWLINE) b = BLANK_MAX;
        return b;
    endfunction

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Value text up to and including its newline, with blanks around it.
    task automatic add_value();
        repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte(1'b0));
        if ($urandom_range(0, 4) != 0) begin
            text_q.push_back(byte_except(33, CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
            repeat ($urandom_range(0, 5))
                text_q.push_back(byte_except(0, CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
        end
        repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte(1'b0));
        text_q.push_back(CH_NEWLINE);
    endtask

    task automatic add_line();
        case ($urandom_range(0, 9))
            0: begin
                text_q.push_back(CH_LBRACK);
                repeat ($urandom_range(0, 6))
                    text_q.push_back(byte_except(0, CH_RBRACK, CH_RBRACK, CH_RBRACK));
                text_q.push_back(CH_RBRACK);
                text_q.push_back(CH_NEWLINE);
            end
            1: begin
                text_q.push_back(CH_HASH);
                repeat ($urandom_range(0, 8))
                    text_q.push_back(byte_except(0, CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
                text_q.push_back(CH_NEWLINE);
            end
            2: begin
                repeat ($urandom_range(0, 3)) text_q.push_back(blank_byte(1'b1));
                text_q.push_back(CH_NEWLINE);
            end
            3: begin
                repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte(1'b1));
                text_q.push_back(CH_EQUALS);
                add_value();
            end
            default: begin
                repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte(1'b1));
                text_q.push_back(byte_except(33, CH_HASH, CH_LBRACK, CH_EQUALS));
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 1) == 0) text_q.push_back(blank_byte(1'b1));
                    else text_q.push_back(byte_except(0, CH_EQUALS, CH_EQUALS, CH_EQUALS));
                end
                repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte(1'b1));
                text_q.push_back(CH_EQUALS);
                add_value();
            end
        endcase
    endtask

    // A few lines, sometimes with raw noise and sometimes cut short.
    task automatic build_text();
        int cut;
        text_q.delete();
        repeat ($urandom_range(1, 4)) add_line();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 6) == 0 && text_q.size() > 1) begin
            cut = $urandom_range(1, (text_q.size() > 9) ? 8 : text_q.size() - 1);
            repeat (cut) void'(text_q.pop_back());
        end
    endtask

    task automatic send_beat(t_in_beat b);
        int gap;
        gap = draw_gap(sender_pace);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(bit mark_last);
        t_in_beat b;
        foreach (text_q[i]) begin
            b.text_byte = text_q[i];
            b.last_byte = mark_last && (i == text_q.size() - 1);
            send_beat(b);
        end
        text_q.delete();
    endtask

    // Hold the input off until every predicted token has come out.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (spans.pending_spans.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        spans = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: high and NUL bytes, a comment holding a bracket, an empty key
        // and empty value, a key with '#' and a newline inside, a trimmed value,
        // then a section and a value cut off by the last byte.
        add_str("[");
        text_q.push_back(8'hFF);
        add_str("]#x]\n");
        text_q.push_back(8'h00);
        add_str("=\nk #\n= v");
        text_q.push_back(8'h80);
        add_str(" \n[u");
        send_text(1'b1);
        add_str("a=b");
        send_text(1'b1);
        pause_until_drained();

        while (bytes_sent < RANDOM_BYTES + 25) begin
            sender_pace   = ($urandom_range(0, 2) != 0);
            receiver_pace = ($urandom_range(0, 2) != 0);
            build_text();
            send_text(1'b1);
            if ($urandom_range(0, 15) == 0) pause_until_drained();
        end
        in_valid <= 1'b0;
        do @(posedge clk); while (spans.pending_spans.size() != 0);
        repeat (10) @(posedge clk);

        if (spans.failures == 0 && spans.pending_spans.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
